// ===== rtl/embr_pkg.sv =====
package embr_pkg;

   localparam int unsigned TABLE_ENTRIES_DEFAULT = 256;

   localparam logic [31:0] HASH_MULT  = 32'd2654435761;
   localparam logic [31:0] SLOT_EMPTY = 32'd0;
   localparam logic [31:0] SLOT_TOMB  = 32'd1;

   localparam logic [3:0] LOAD_LIMIT_RESET = 4'd7;
   localparam logic [3:0] LOAD_LIMIT_MAX   = 4'd9;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_TAKE   = 1'b1;

   typedef enum logic [2:0] {
      ST_RECORDED  = 3'd0,
      ST_REFUSED   = 3'd1,
      ST_TAKEN     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_PARTIAL   = 3'd4
   } status_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] base_address;
      logic [31:0] block_size;
   } req_word_type;

   typedef struct packed {
      status_type  status;
      logic [8:0]  live_count;
   } rsp_word_type;

   typedef struct packed {
      logic       clear;
      logic       capture;
      logic       advance;
      logic       write_rec;
      logic       write_tomb;
      logic       finish;
      status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic early_stop;
      logic operation;
      logic slot_empty;
      logic slot_free;
      logic base_hit;
      logic size_hit;
      logic probe_last;
   } dp_status_type;

endpackage

// ===== rtl/embr_ctrl.sv =====
module embr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  embr_pkg::dp_status_type dp_status,
   output embr_pkg::ctrl_cmd_type  cmd
);
   import embr_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_READ  = 4'b0100,
      S_CHECK = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (dp_status.probe_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            // The slot read issued here lands in the read register for the check.
            if (dp_status.early_stop) begin
               cmd.finish = 1'b1;
               cmd.status = (dp_status.operation == OP_RECORD) ? ST_REFUSED : ST_NOT_FOUND;
               state_in   = S_IDLE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (dp_status.operation == OP_RECORD) begin
               if (dp_status.slot_free) begin
                  cmd.write_rec = 1'b1;
                  cmd.finish    = 1'b1;
                  cmd.status    = ST_RECORDED;
                  state_in      = S_IDLE;
               end else if (dp_status.probe_last) begin
                  cmd.finish = 1'b1;
                  cmd.status = ST_REFUSED;
                  state_in   = S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_READ;
               end
            end else begin
               if (dp_status.slot_empty) begin
                  cmd.finish = 1'b1;
                  cmd.status = ST_NOT_FOUND;
                  state_in   = S_IDLE;
               end else if (dp_status.base_hit) begin
                  cmd.finish     = 1'b1;
                  cmd.write_tomb = dp_status.size_hit;
                  cmd.status     = dp_status.size_hit ? ST_TAKEN : ST_PARTIAL;
                  state_in       = S_IDLE;
               end else if (dp_status.probe_last) begin
                  cmd.finish = 1'b1;
                  cmd.status = ST_NOT_FOUND;
                  state_in   = S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/embr_datapath.sv =====
module embr_datapath #(
   parameter int unsigned TABLE_ENTRIES = embr_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  embr_pkg::req_word_type  req_word,
   input  logic                   csr_we,
   input  logic [3:0]             csr_wdata,
   input  embr_pkg::ctrl_cmd_type  cmd,
   output embr_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   output embr_pkg::rsp_word_type  rsp_word
);
   import embr_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam int unsigned CNT_W = IDX_W + 1;
   localparam int unsigned LW    = CNT_W + 4;

   logic [31:0]      base_mem [TABLE_ENTRIES];
   logic [31:0]      size_mem [TABLE_ENTRIES];

   req_word_type     req_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] probe_ff;
   logic [31:0]      rd_base_ff;
   logic [31:0]      rd_size_ff;
   logic [CNT_W-1:0] live_ff;
   logic [CNT_W-1:0] live_in;
   logic [CNT_W-1:0] used_ff;
   logic [CNT_W-1:0] used_in;
   logic [3:0]       limit_ff;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;

   logic [2*IDX_W-1:0] hash_prod;
   logic [IDX_W-1:0]   home_idx;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [31:0]        mem_wdata;
   logic [3:0]         limit_c;
   logic [LW-1:0]      used_plus;
   logic [LW-1:0]      load_lhs;
   logic [LW-1:0]      load_rhs;
   logic               load_full;
   logic               reserved;
   logic [CNT_W+8:0]   live_ext;

   // Only the low index bits of the product matter, so a narrow multiply suffices.
   assign hash_prod = req_word.base_address[IDX_W+3:4] * HASH_MULT[IDX_W-1:0];
   assign home_idx  = hash_prod[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_word;
      end
      if (cmd.capture) begin
         idx_ff <= home_idx;
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // The probe counter also walks the table during the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else if (cmd.capture) begin
         probe_ff <= '0;
      end else if (cmd.clear || cmd.advance) begin
         probe_ff <= probe_ff + 1'b1;
      end
   end

   assign mem_we    = cmd.clear || cmd.write_rec || cmd.write_tomb;
   assign mem_waddr = cmd.clear ? probe_ff : idx_ff;

   always_comb begin
      priority if (cmd.clear) begin
         mem_wdata = SLOT_EMPTY;
      end else if (cmd.write_rec) begin
         mem_wdata = req_ff.base_address;
      end else begin
         mem_wdata = SLOT_TOMB;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         base_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.write_rec) begin
         size_mem[idx_ff] <= req_ff.block_size;
      end
      rd_base_ff <= base_mem[idx_ff];
      rd_size_ff <= size_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LOAD_LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   assign limit_c   = (limit_ff > LOAD_LIMIT_MAX) ? LOAD_LIMIT_MAX : limit_ff;
   assign used_plus = LW'(used_ff) + 1'b1;
   assign load_lhs  = (used_plus << 3) + (used_plus << 1);
   assign load_rhs  = LW'(limit_c) << IDX_W;
   assign load_full = (load_lhs >= load_rhs);
   assign reserved  = (req_ff.base_address == SLOT_EMPTY) || (req_ff.base_address == SLOT_TOMB);

   always_comb begin
      live_in = live_ff;
      used_in = used_ff;
      if (cmd.write_rec) begin
         live_in = live_ff + 1'b1;
         if (rd_base_ff == SLOT_EMPTY) begin
            used_in = used_ff + 1'b1;
         end
      end else if (cmd.write_tomb && (live_ff != '0)) begin
         live_in = live_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         used_ff <= '0;
      end else begin
         live_ff <= live_in;
         used_ff <= used_in;
      end
   end

   assign live_ext = {9'b0, live_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         rsp_word_ff.status     <= cmd.status;
         rsp_word_ff.live_count <= live_ext[8:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign dp_status.early_stop = reserved || ((req_ff.operation == OP_RECORD) && load_full);
   assign dp_status.operation  = req_ff.operation;
   assign dp_status.slot_empty = (rd_base_ff == SLOT_EMPTY);
   assign dp_status.slot_free  = (rd_base_ff == SLOT_EMPTY) || (rd_base_ff == SLOT_TOMB);
   assign dp_status.base_hit   = (rd_base_ff == req_ff.base_address);
   assign dp_status.size_hit   = (rd_size_ff == req_ff.block_size);
   assign dp_status.probe_last = &probe_ff;

endmodule

// ===== rtl/exact_match_block_registry_core.sv =====
// Channel    Ports                          Transfer
// request    start, busy, req_word          start high while busy is low
// response   rsp_valid, rsp_word            one-cycle strobe, always taken
// config     csr_valid, csr_ready, csr_wdata valid and ready both high
//
// After acceptance an item alternates read and check steps until the strobe rises;
// each probe is one read of the slot table plus one check.
// Refused or reserved-base items finish in the read step without probing.
// Reset starts a clearing pass over every slot that empties the slot table;
// busy stays high until it ends. The result strobe cannot be stalled, and a new item
// may be accepted in the cycle the previous result is shown.
module exact_match_block_registry_core #(
   parameter int unsigned TABLE_ENTRIES = embr_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  embr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output embr_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [3:0]            csr_wdata
);
   import embr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   embr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   embr_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== rtl/embr_checker.sv =====
module embr_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input embr_pkg::rsp_word_type rsp_word
);
   import embr_pkg::*;

   // The clearing pass keeps the block busy right after reset.
   a_busy_after_reset: assert property (@(posedge clock) (!reset && $past(reset)) |-> busy)
      else $error("block not busy after reset");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted word did not make the block busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without outstanding request word");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.status == ST_RECORDED || rsp_word.status == ST_REFUSED ||
                     rsp_word.status == ST_TAKEN || rsp_word.status == ST_NOT_FOUND ||
                     rsp_word.status == ST_PARTIAL))
      else $error("result word carries an undefined status");

endmodule

bind exact_match_block_registry_core embr_checker u_checker (.*);
